// ===== sv/rdv_pkg.sv =====
// ----------------------------------------------------------------------------
// rdv_pkg
// Shared types and constants for the rendezvous endpoint queue engine.
// ----------------------------------------------------------------------------
package rdv_pkg;

    localparam int NUM_PROCS     = 64;
    localparam int NUM_ENDPOINTS = 16;
    localparam int MSG_BITS      = 64;
    localparam int BADGE_BITS    = 32;

    localparam int PID_W = $clog2(NUM_PROCS);
    localparam int EP_W  = $clog2(NUM_ENDPOINTS);

    typedef logic [PID_W-1:0]      pid_t;
    typedef logic [EP_W-1:0]       ep_t;
    typedef logic [MSG_BITS-1:0]   msg_t;
    typedef logic [BADGE_BITS-1:0] badge_t;

    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_BLOCKED  = 2'd1,
        STATUS_REJECTED = 2'd2
    } status_t;

    typedef enum logic {
        CMD_SEND = 1'b0,
        CMD_RECV = 1'b1
    } cmd_t;

    // queue pointers of one endpoint plus the caller's blocked bit
    typedef struct packed {
        pid_t send_head;
        pid_t send_tail;
        logic send_ne;
        pid_t recv_head;
        pid_t recv_tail;
        logic recv_ne;
        logic caller_blocked;
    } queue_view_t;

    typedef struct packed {
        logic send_we;
        pid_t send_head;
        pid_t send_tail;
        logic send_ne;
        logic recv_we;
        pid_t recv_head;
        pid_t recv_tail;
        logic recv_ne;
        logic blk_set;
        logic blk_clr;
        pid_t clr_pid;
    } queue_upd_t;

    typedef struct packed {
        logic   link_we;
        pid_t   link_addr;
        pid_t   link_data;
        logic   park_we;
        pid_t   park_addr;
        msg_t   msg;
        badge_t badge;
    } slot_wr_t;

    typedef struct packed {
        status_t status;
        pid_t    woken;
        pid_t    target;
        msg_t    msg;
        badge_t  badge;
    } result_t;

endpackage

// ===== sv/rendezvous_endpoint_queues_top.sv =====
// ----------------------------------------------------------------------------
// rendezvous_endpoint_queues_top
// Send/receive rendezvous engine over per-endpoint FIFOs of blocked slots.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one request (cmd, endpoint,
//   caller_pid, message, badge); output channel out_valid/out_ready carries
//   exactly one result per request (status, woken_pid, recipient_pid, msg_out,
//   badge_out), in request order.
//   at the accept edge of a request the endpoint's pointers are
//   captured and the slot memory is read at the queue head; at the commit
//   edge the decision commits to the pointers, blocked bits and slot memory
//   and loads the result register, and out_valid rises.
//   a new request is accepted only after the previous one has committed,
//   as the registered read of the slot memory precedes each commit.
//   reset empties every endpoint queue and clears every blocked bit; the slot
//   memories are not cleared, since an entry is only used after being written.
//   when out_ready is low the result register holds its result; one more
//   request is still accepted and waits in the commit stage until the result
//   is taken.
// ----------------------------------------------------------------------------
module rendezvous_endpoint_queues_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  rdv_pkg::ep_t     endpoint,
    input  rdv_pkg::pid_t    caller_pid,
    input  rdv_pkg::msg_t    message,
    input  rdv_pkg::badge_t  badge,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output rdv_pkg::pid_t    woken_pid,
    output rdv_pkg::pid_t    recipient_pid,
    output rdv_pkg::msg_t    msg_out,
    output rdv_pkg::badge_t  badge_out
);
    import rdv_pkg::*;

    logic        busy_reg;
    logic        out_valid_reg;
    logic        cmd_reg;
    ep_t         ep_reg;
    pid_t        caller_reg;
    msg_t        msg_reg;
    badge_t      badge_reg;
    queue_view_t view_reg;
    result_t     res_reg;

    queue_view_t view;
    queue_upd_t  upd;
    slot_wr_t    wr;
    result_t     res;
    pid_t        link_rd;
    msg_t        msg_rd;
    badge_t      badge_rd;
    pid_t        rd_addr;
    logic        accept;
    logic        commit;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign commit   = busy_reg && (!out_valid_reg || out_ready);

    // head of the queue this request may pop
    assign rd_addr = (cmd == CMD_RECV) ? view.send_head : view.recv_head;

    rdv_queue_regs u_queue_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_ep  (endpoint),
        .lookup_pid (caller_pid),
        .view       (view),
        .upd_en     (commit),
        .upd_ep     (ep_reg),
        .upd_pid    (caller_reg),
        .upd        (upd)
    );

    rdv_slot_mem u_slot_mem (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .wr       (commit ? wr : '0),
        .link_rd  (link_rd),
        .msg_rd   (msg_rd),
        .badge_rd (badge_rd)
    );

    rdv_match u_match (
        .cmd      (cmd_reg),
        .caller   (caller_reg),
        .message  (msg_reg),
        .badge    (badge_reg),
        .view     (view_reg),
        .link_rd  (link_rd),
        .msg_rd   (msg_rd),
        .badge_rd (badge_rd),
        .upd      (upd),
        .wr       (wr),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            ep_reg     <= endpoint;
            caller_reg <= caller_pid;
            msg_reg    <= message;
            badge_reg  <= badge;
            view_reg   <= view;
        end
        if (commit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign woken_pid     = res_reg.woken;
    assign recipient_pid = res_reg.target;
    assign msg_out       = res_reg.msg;
    assign badge_out     = res_reg.badge;

endmodule

// ===== sv/rdv_slot_mem.sv =====
// ----------------------------------------------------------------------------
// rdv_slot_mem
// Per-slot storage: queue links, parked messages and parked badges.
// ----------------------------------------------------------------------------
module rdv_slot_mem (
    input  logic             clk,
    input  logic             rd_en,
    input  rdv_pkg::pid_t    rd_addr,
    input  rdv_pkg::slot_wr_t wr,
    output rdv_pkg::pid_t    link_rd,
    output rdv_pkg::msg_t    msg_rd,
    output rdv_pkg::badge_t  badge_rd
);
    import rdv_pkg::*;

    pid_t   link_mem  [NUM_PROCS];
    msg_t   msg_mem   [NUM_PROCS];
    badge_t badge_mem [NUM_PROCS];

    pid_t   link_rd_reg;
    msg_t   msg_rd_reg;
    badge_t badge_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.link_we)
        begin
            link_mem[wr.link_addr] <= wr.link_data;
        end
        if (wr.park_we)
        begin
            msg_mem[wr.park_addr]   <= wr.msg;
            badge_mem[wr.park_addr] <= wr.badge;
        end
    end

    // read data holds between requests
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            link_rd_reg  <= link_mem[rd_addr];
            msg_rd_reg   <= msg_mem[rd_addr];
            badge_rd_reg <= badge_mem[rd_addr];
        end
    end

    assign link_rd  = link_rd_reg;
    assign msg_rd   = msg_rd_reg;
    assign badge_rd = badge_rd_reg;

endmodule

// ===== sv/rdv_queue_regs.sv =====
// ----------------------------------------------------------------------------
// rdv_queue_regs
// Head/tail pointers and non-empty bits per endpoint, blocked bit per slot.
// ----------------------------------------------------------------------------
module rdv_queue_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rdv_pkg::ep_t         lookup_ep,
    input  rdv_pkg::pid_t        lookup_pid,
    output rdv_pkg::queue_view_t view,
    input  logic                 upd_en,
    input  rdv_pkg::ep_t         upd_ep,
    input  rdv_pkg::pid_t        upd_pid,
    input  rdv_pkg::queue_upd_t  upd
);
    import rdv_pkg::*;

    pid_t send_head_reg [NUM_ENDPOINTS];
    pid_t send_tail_reg [NUM_ENDPOINTS];
    pid_t recv_head_reg [NUM_ENDPOINTS];
    pid_t recv_tail_reg [NUM_ENDPOINTS];
    logic [NUM_ENDPOINTS-1:0] send_ne_reg;
    logic [NUM_ENDPOINTS-1:0] recv_ne_reg;
    logic [NUM_PROCS-1:0]     blocked_reg;

    always_comb
    begin
        view.send_head      = send_head_reg[lookup_ep];
        view.send_tail      = send_tail_reg[lookup_ep];
        view.send_ne        = send_ne_reg[lookup_ep];
        view.recv_head      = recv_head_reg[lookup_ep];
        view.recv_tail      = recv_tail_reg[lookup_ep];
        view.recv_ne        = recv_ne_reg[lookup_ep];
        view.caller_blocked = blocked_reg[lookup_pid];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENDPOINTS; i++)
            begin
                send_head_reg[i] <= '0;
                send_tail_reg[i] <= '0;
                recv_head_reg[i] <= '0;
                recv_tail_reg[i] <= '0;
            end
            send_ne_reg <= '0;
            recv_ne_reg <= '0;
            blocked_reg <= '0;
        end
        else if (upd_en)
        begin
            if (upd.send_we)
            begin
                send_head_reg[upd_ep] <= upd.send_head;
                send_tail_reg[upd_ep] <= upd.send_tail;
                send_ne_reg[upd_ep]   <= upd.send_ne;
            end
            if (upd.recv_we)
            begin
                recv_head_reg[upd_ep] <= upd.recv_head;
                recv_tail_reg[upd_ep] <= upd.recv_tail;
                recv_ne_reg[upd_ep]   <= upd.recv_ne;
            end
            if (upd.blk_set)
            begin
                blocked_reg[upd_pid] <= 1'b1;
            end
            if (upd.blk_clr)
            begin
                blocked_reg[upd.clr_pid] <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/rdv_match.sv =====
// ----------------------------------------------------------------------------
// rdv_match
// Decides rendezvous, park or reject for one request and forms the updates.
// ----------------------------------------------------------------------------
module rdv_match (
    input  logic                 cmd,
    input  rdv_pkg::pid_t        caller,
    input  rdv_pkg::msg_t        message,
    input  rdv_pkg::badge_t      badge,
    input  rdv_pkg::queue_view_t view,
    input  rdv_pkg::pid_t        link_rd,
    input  rdv_pkg::msg_t        msg_rd,
    input  rdv_pkg::badge_t      badge_rd,
    output rdv_pkg::queue_upd_t  upd,
    output rdv_pkg::slot_wr_t    wr,
    output rdv_pkg::result_t     res
);
    import rdv_pkg::*;

    always_comb
    begin
        upd        = '0;
        wr         = '0;
        res        = '0;
        res.status = STATUS_REJECTED;

        if (view.caller_blocked)
        begin
            res.status = STATUS_REJECTED;
        end
        else if (cmd == CMD_SEND)
        begin
            if (view.recv_ne)
            begin
                // pop the oldest receiver and hand it this message
                upd.recv_we   = 1'b1;
                upd.recv_tail = view.recv_tail;
                if (view.recv_head == view.recv_tail)
                begin
                    upd.recv_head = view.recv_head;
                    upd.recv_ne   = 1'b0;
                end
                else
                begin
                    upd.recv_head = link_rd;
                    upd.recv_ne   = 1'b1;
                end
                upd.blk_clr = 1'b1;
                upd.clr_pid = view.recv_head;
                res.status  = STATUS_DONE;
                res.woken   = view.recv_head;
                res.target  = view.recv_head;
                res.msg     = message;
                res.badge   = badge;
            end
            else
            begin
                wr.park_we    = 1'b1;
                wr.park_addr  = caller;
                wr.msg        = message;
                wr.badge      = badge;
                upd.send_we   = 1'b1;
                upd.send_tail = caller;
                upd.send_ne   = 1'b1;
                if (view.send_ne)
                begin
                    wr.link_we    = 1'b1;
                    wr.link_addr  = view.send_tail;
                    wr.link_data  = caller;
                    upd.send_head = view.send_head;
                end
                else
                begin
                    upd.send_head = caller;
                end
                upd.blk_set = 1'b1;
                res.status  = STATUS_BLOCKED;
            end
        end
        else
        begin
            if (view.send_ne)
            begin
                // pop the oldest sender and deliver its parked message
                upd.send_we   = 1'b1;
                upd.send_tail = view.send_tail;
                if (view.send_head == view.send_tail)
                begin
                    upd.send_head = view.send_head;
                    upd.send_ne   = 1'b0;
                end
                else
                begin
                    upd.send_head = link_rd;
                    upd.send_ne   = 1'b1;
                end
                upd.blk_clr = 1'b1;
                upd.clr_pid = view.send_head;
                res.status  = STATUS_DONE;
                res.woken   = view.send_head;
                res.target  = caller;
                res.msg     = msg_rd;
                res.badge   = badge_rd;
            end
            else
            begin
                upd.recv_we   = 1'b1;
                upd.recv_tail = caller;
                upd.recv_ne   = 1'b1;
                if (view.recv_ne)
                begin
                    wr.link_we    = 1'b1;
                    wr.link_addr  = view.recv_tail;
                    wr.link_data  = caller;
                    upd.recv_head = view.recv_head;
                end
                else
                begin
                    upd.recv_head = caller;
                end
                upd.blk_set = 1'b1;
                res.status  = STATUS_BLOCKED;
            end
        end
    end

endmodule
